@@ sv/dksit_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-key sorted table package
// Shared sizes, request and status codes, the record type and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dksit_pkg;

  // Table size and the widths derived from it.
  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths.
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned SHARE_W = 20;
  localparam int unsigned GAIN_W  = 45;
  localparam int unsigned ORDER_W = 2;

  // Request codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LIST   = 1'b1;

  // Bits of the list order: key select (set means gain) and direction.
  localparam int unsigned ORDER_KEY_BIT  = 0;
  localparam int unsigned ORDER_DESC_BIT = 1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_RECORD = 2'd0,
    STATUS_ACCEPT = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_e;

  // One stored record.
  typedef struct packed {
    logic [CODE_W-1:0]        code;
    logic signed [GAIN_W-1:0] gain;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    compare;
    logic    write;
    logic    load_reply;
    status_e reply_status;
    logic    load_rec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic list_last;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/dksit_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-key sorted table datapath
// Gain multiplier, the two shifting sorted stores, the entry count, the list
// walk counter and the output register.
// ----------------------------------------------------------------------------
module dksit_dp (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire dksit_pkg::cmd_t           cmd_i,
  output dksit_pkg::sts_t                sts_o,
  input  wire [dksit_pkg::CODE_W-1:0]    key_code_i,
  input  wire [dksit_pkg::PRICE_W-1:0]   spot_price_i,
  input  wire [dksit_pkg::PRICE_W-1:0]   buy_price_i,
  input  wire [dksit_pkg::SHARE_W-1:0]   share_count_i,
  input  wire [dksit_pkg::ORDER_W-1:0]   list_order_i,
  output logic [1:0]                     status_o,
  output logic [dksit_pkg::CODE_W-1:0]   out_code_o,
  output logic signed [dksit_pkg::GAIN_W-1:0] out_gain_o,
  output logic                           last_o
);
  import dksit_pkg::*;

  rec_t by_code_q [DEPTH];
  rec_t by_code_d [DEPTH];
  rec_t by_gain_q [DEPTH];
  rec_t by_gain_d [DEPTH];
  rec_t new_q;
  rec_t rec_sel;

  logic [ORDER_W-1:0]      order_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        k_q;
  logic [DEPTH-1:0]        gt_code_q, gt_code_d;
  logic [DEPTH-1:0]        gt_gain_q, gt_gain_d;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [PRICE_W:0] diff;
  logic signed [GAIN_W:0]  prod;

  // Gain in hundredths: price difference times share count.
  always_comb begin
    diff = $signed({1'b0, spot_price_i}) - $signed({1'b0, buy_price_i});
    prod = diff * $signed({1'b0, share_count_i});
  end

  // Capture the request payload when a transaction is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_q.code <= key_code_i;
      new_q.gain <= prod[GAIN_W-1:0];
      order_q    <= list_order_i;
    end
  end

  // Compare the new keys against every occupied entry.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt_code_d[i] = (CNT_W'(i) < count_q) && (new_q.code > by_code_q[i].code);
      gt_gain_d[i] = (CNT_W'(i) < count_q) &&
                     ($signed(new_q.gain) > $signed(by_gain_q[i].gain));
    end
  end

  // An entry keeps its record while the new key is greater, takes the new
  // record at the boundary, and takes its lower neighbor above it.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      by_code_d[i] = by_code_q[i];
      by_gain_d[i] = by_gain_q[i];
    end
    if (!gt_code_q[0]) by_code_d[0] = new_q;
    if (!gt_gain_q[0]) by_gain_d[0] = new_q;
    for (int i = 1; i < DEPTH; i++) begin
      if (CNT_W'(i) <= count_q) begin
        if (!gt_code_q[i]) begin
          by_code_d[i] = gt_code_q[i-1] ? new_q : by_code_q[i-1];
        end
        if (!gt_gain_q[i]) begin
          by_gain_d[i] = gt_gain_q[i-1] ? new_q : by_gain_q[i-1];
        end
      end
    end
  end

  // Store update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      by_code_q <= by_code_d;
      by_gain_q <= by_gain_d;
    end
  end

  // Compare flags, entry count and list walk counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_code_q <= '0;
      gt_gain_q <= '0;
      count_q   <= '0;
      k_q       <= '0;
    end else begin
      if (cmd_i.compare) begin
        gt_code_q <= gt_code_d;
        gt_gain_q <= gt_gain_d;
      end
      if (cmd_i.write) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.capture) begin
        k_q <= '0;
      end else if (cmd_i.load_rec) begin
        k_q <= k_q + CNT_W'(1);
      end
    end
  end

  // List read address: walk from the bottom, or from the top when descending.
  always_comb begin
    if (order_q[ORDER_DESC_BIT]) begin
      rd_idx = IDX_W'(count_q - CNT_W'(1) - k_q);
    end else begin
      rd_idx = IDX_W'(k_q);
    end
    rec_sel = order_q[ORDER_KEY_BIT] ? by_gain_q[rd_idx] : by_code_q[rd_idx];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rec) begin
      status_o   <= STATUS_RECORD;
      out_code_o <= rec_sel.code;
      out_gain_o <= rec_sel.gain;
      last_o     <= sts_o.list_last;
    end else if (cmd_i.load_reply) begin
      status_o   <= cmd_i.reply_status;
      out_code_o <= '0;
      out_gain_o <= '0;
      last_o     <= 1'b1;
    end
  end

  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.list_last = ((k_q + CNT_W'(1)) == count_q);

  // The count never runs past the table size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds table size");

  // A store update never happens on a full table.
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> !sts_o.full)
    else $error("store written while full");

  // Sorted stores give a run of greater-than flags from entry zero.
  a_code_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gt_code_q & (gt_code_q + DEPTH'(1))) == '0)
    else $error("code store out of order");

  a_gain_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gt_gain_q & (gt_gain_q + DEPTH'(1))) == '0)
    else $error("gain store out of order");

endmodule
`default_nettype wire

@@ sv/dksit_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-key sorted table controller
// Sequences inserts and list walks and drives the input and output
// handshakes.
// ----------------------------------------------------------------------------
module dksit_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  func_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output dksit_pkg::cmd_t      cmd_o,
  input  wire dksit_pkg::sts_t sts_i
);
  import dksit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_WRITE,
    S_REPLY,
    S_LIST
  } state_e;

  state_e  state_q, state_d;
  status_e reply_q, reply_d;
  logic    out_valid_q, out_valid_d;
  logic    in_accept;
  logic    out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Commands to the datapath.
  always_comb begin
    cmd_o              = '0;
    cmd_o.reply_status = reply_q;
    cmd_o.capture      = in_accept;
    cmd_o.compare      = (state_q == S_COMPARE);
    cmd_o.write        = (state_q == S_WRITE);
    cmd_o.load_reply   = (state_q == S_REPLY) && out_free;
    cmd_o.load_rec     = (state_q == S_LIST) && out_free;
  end

  // Next state.
  always_comb begin
    state_d     = state_q;
    reply_d     = reply_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (func_i == FUNC_INSERT) begin
            if (sts_i.full) begin
              reply_d = STATUS_FULL;
              state_d = S_REPLY;
            end else begin
              reply_d = STATUS_ACCEPT;
              state_d = S_COMPARE;
            end
          end else if (sts_i.empty) begin
            reply_d = STATUS_EMPTY;
            state_d = S_REPLY;
          end else begin
            state_d = S_LIST;
          end
        end
      end
      S_COMPARE: state_d = S_WRITE;
      S_WRITE:   state_d = S_REPLY;
      S_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sts_i.list_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      reply_q     <= STATUS_ACCEPT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_reply || cmd_o.load_rec) |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while held");

  // A loaded result shows as valid on the next cycle.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_reply || cmd_o.load_rec) |=> out_valid_q)
    else $error("loaded result not presented");

  // An insert always runs through compare then write.
  a_insert_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPARE) |=> (state_q == S_WRITE))
    else $error("insert sequence broken");

endmodule
`default_nettype wire

@@ sv/dual_key_sorted_insert_table.sv @@
`default_nettype none
// Insert: the new record is compared against both stores, the stores shift
// and the reply is loaded into the output register; an insert into a full
// table goes straight to the reply. The next request is taken once the reply
// is loaded. List: one record per cycle while the output is not stalled, set
// by the single store read port; an empty table gets one empty reply. Reset
// clears the entry count; store contents stay undefined until written.
// ----------------------------------------------------------------------------
// Dual-key sorted insert table
// Keeps (code, gain) records in two stores, ordered by code and by gain, and
// lists them in any of four orders.
// ----------------------------------------------------------------------------
module dual_key_sorted_insert_table (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 func_i,
  input  wire [dksit_pkg::CODE_W-1:0]         key_code_i,
  input  wire [dksit_pkg::PRICE_W-1:0]        spot_price_i,
  input  wire [dksit_pkg::PRICE_W-1:0]        buy_price_i,
  input  wire [dksit_pkg::SHARE_W-1:0]        share_count_i,
  input  wire [dksit_pkg::ORDER_W-1:0]        list_order_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [1:0]                          status_o,
  output logic [dksit_pkg::CODE_W-1:0]        out_code_o,
  output logic signed [dksit_pkg::GAIN_W-1:0] out_gain_o,
  output logic                                last_o
);
  import dksit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  dksit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Stores, arithmetic and output register.
  dksit_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .key_code_i    (key_code_i),
    .spot_price_i  (spot_price_i),
    .buy_price_i   (buy_price_i),
    .share_count_i (share_count_i),
    .list_order_i  (list_order_i),
    .status_o      (status_o),
    .out_code_o    (out_code_o),
    .out_gain_o    (out_gain_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
